// ----- src/request_coalescing_batcher_assert.svh -----
// assertion macros for the request coalescing batcher
// used by the engine module, expects clk and rst_n in scope
`ifndef REQUEST_COALESCING_BATCHER_ASSERT_SVH
`define REQUEST_COALESCING_BATCHER_ASSERT_SVH
`ifndef SYNTH
`define RCB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCB_ASSERT(label, cond, msg)
`define RCB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/rcb_pkg.sv -----
// shared types and constants of the request coalescing batcher
// no dependencies
`default_nettype none
package rcb_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_TAGS_DEF      = 8;
    localparam int BATCH_MAX_DEF     = 16;

    localparam int KEY_W   = 64;
    localparam int TAG_W   = 3;
    localparam int WAIT_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ILIM_W  = 4;
    localparam int BLIM_W  = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [WAIT_W-1:0] WAIT_MAX = 8'hFF;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DONE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ISSUE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INFLIGHT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH    = 4'd1;

    localparam logic [ILIM_W-1:0] ILIM_RESET = 4'd1;
    localparam logic [BLIM_W-1:0] BLIM_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DONE = 2'd1,
        CMD_ZERO = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic               ok;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   tag;
        logic [KEY_W-1:0]   key;
        logic [WAIT_W-1:0]  waiters;
        logic               ok;
        logic               last;
    } out_t;

endpackage
`default_nettype wire

// ----- src/rcb_front.sv -----
// front end: accepts input transactions, classifies them into commands
// and holds them in a two-entry queue; depends on rcb_pkg
`default_nettype none
module rcb_front
    import rcb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              opcode,
    input  wire logic [KEY_W-1:0]  query_key,
    input  wire logic [TAG_W-1:0]  done_tag,
    input  wire logic              done_ok,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output cmd_t                   cmd
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       new_cmd;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        new_cmd.key = query_key;
        new_cmd.tag = done_tag;
        new_cmd.ok  = done_ok;
        if (opcode == OP_DONE)
        begin
            new_cmd.kind = CMD_DONE;
        end
        else if (query_key == '0)
        begin
            new_cmd.kind = CMD_ZERO;
        end
        else
        begin
            new_cmd.kind = CMD_ADD;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- src/rcb_engine.sv -----
// back end: key table, pending queue, batch bookkeeping and result register
// depends on rcb_pkg and request_coalescing_batcher_assert.svh
`default_nettype none
`include "request_coalescing_batcher_assert.svh"
module rcb_engine
    import rcb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_TAGS      = MAX_TAGS_DEF,
    parameter int BATCH_MAX     = BATCH_MAX_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ILIM_W-1:0] inflight_limit,
    input  wire logic [BLIM_W-1:0] batch_size_limit,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmd_t              cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_t                   out_item
);

    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int TW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int BW = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int LW = $clog2(BATCH_MAX + 1);
    localparam int IW = $clog2(MAX_TAGS + 1);
    localparam int BM_DEPTH = MAX_TAGS * (1 << BW);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_SCAN      = 13'b0000000000010,
        ST_HIT_RD    = 13'b0000000000100,
        ST_HIT_WR    = 13'b0000000001000,
        ST_ALLOC     = 13'b0000000010000,
        ST_REJECT    = 13'b0000000100000,
        ST_DONE_RD   = 13'b0000001000000,
        ST_DONE_ENT  = 13'b0000010000000,
        ST_DONE_EMIT = 13'b0000100000000,
        ST_ISSUE     = 13'b0001000000000,
        ST_ISS_RD    = 13'b0010000000000,
        ST_ISS_ENT   = 13'b0100000000000,
        ST_ISS_EMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    logic [CW-1:0] scan_ptr_reg, scan_ptr_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [EW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          free_vld_reg, free_vld_next;
    logic [EW-1:0] free_idx_reg, free_idx_next;
    logic [EW-1:0] hit_idx_reg, hit_idx_next;
    logic [EW-1:0] ent_reg, ent_next;

    logic [TABLE_ENTRIES-1:0] used_reg, used_next;
    logic [MAX_TAGS-1:0]      tag_busy_reg, tag_busy_next;
    logic [LW-1:0]            blen_reg [MAX_TAGS];
    logic [LW-1:0]            blen_next [MAX_TAGS];
    logic [IW-1:0]            inflight_reg, inflight_next;
    logic [EW-1:0]            q_head_reg, q_head_next;
    logic [EW-1:0]            q_tail_reg, q_tail_next;
    logic [CW-1:0]            q_count_reg, q_count_next;
    logic [TW-1:0]            cur_tag_reg, cur_tag_next;
    logic [LW-1:0]            cur_len_reg, cur_len_next;
    logic [LW-1:0]            elem_reg, elem_next;
    out_t                     out_reg, out_next;
    logic                     out_vld_reg, out_vld_next;

    logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
    logic [WAIT_W-1:0] wait_mem [TABLE_ENTRIES];
    logic [EW-1:0]     pq_mem   [TABLE_ENTRIES];
    logic [EW-1:0]     bm_mem   [BM_DEPTH];

    logic [KEY_W-1:0]  key_rd_reg;
    logic [WAIT_W-1:0] wait_rd_reg;
    logic [EW-1:0]     pq_rd_reg;
    logic [EW-1:0]     bm_rd_reg;

    logic [EW-1:0]     key_raddr, wait_raddr;
    logic              key_we, wait_we, pq_we, bm_we;
    logic [EW-1:0]     key_waddr, wait_waddr;
    logic [WAIT_W-1:0] wait_wdata;
    logic [TW+BW-1:0]  bm_addr;

    logic              slot_free;
    logic              load;
    logic              ftag_vld;
    logic [TW-1:0]     ftag;
    logic [31:0]       bs32, len32;
    logic              elem_last;
    logic [TW-1:0]     done_idx;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;
    assign slot_free = !out_vld_reg || out_ready;
    assign bm_addr   = {cur_tag_reg, elem_reg[BW-1:0]};
    assign elem_last = (LW'(elem_reg + 1'b1) == cur_len_reg);
    assign done_idx  = TW'(cmd.tag);

    always_comb
    begin
        ftag_vld = 1'b0;
        ftag     = '0;
        for (int k = MAX_TAGS - 1; k >= 0; k--)
        begin
            if (!tag_busy_reg[k])
            begin
                ftag_vld = 1'b1;
                ftag     = TW'(k);
            end
        end
        bs32 = 32'(batch_size_limit);
        if (bs32 == 32'd0)
        begin
            bs32 = 32'd1;
        end
        if (bs32 > 32'(BATCH_MAX))
        begin
            bs32 = 32'(BATCH_MAX);
        end
        len32 = (32'(q_count_reg) < bs32) ? 32'(q_count_reg) : bs32;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        scan_ptr_next = scan_ptr_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        hit_idx_next  = hit_idx_reg;
        ent_next      = ent_reg;
        used_next     = used_reg;
        tag_busy_next = tag_busy_reg;
        blen_next     = blen_reg;
        inflight_next = inflight_reg;
        q_head_next   = q_head_reg;
        q_tail_next   = q_tail_reg;
        q_count_next  = q_count_reg;
        cur_tag_next  = cur_tag_reg;
        cur_len_next  = cur_len_reg;
        elem_next     = elem_reg;
        out_next      = out_reg;
        load          = 1'b0;
        key_raddr     = ent_reg;
        wait_raddr    = ent_reg;
        key_we        = 1'b0;
        key_waddr     = free_idx_reg;
        wait_we       = 1'b0;
        wait_waddr    = free_idx_reg;
        wait_wdata    = 8'd1;
        pq_we         = 1'b0;
        bm_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    case (cmd.kind)
                        CMD_ADD:
                        begin
                            scan_ptr_next = '0;
                            free_vld_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        CMD_DONE:
                        begin
                            if (32'(cmd.tag) < 32'(MAX_TAGS) && tag_busy_reg[done_idx])
                            begin
                                cur_tag_next = done_idx;
                                cur_len_next = blen_reg[done_idx];
                                elem_next    = '0;
                                state_next   = ST_DONE_RD;
                            end
                            else
                            begin
                                state_next = ST_REJECT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_REJECT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                key_raddr = scan_ptr_reg[EW-1:0];
                if (scan_ptr_reg < CW'(TABLE_ENTRIES))
                begin
                    scan_ptr_next = scan_ptr_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_ptr_reg[EW-1:0];
                end
                if (cmp_vld_reg)
                begin
                    if (used_reg[cmp_idx_reg] && key_rd_reg == cmd_reg.key)
                    begin
                        hit_idx_next = cmp_idx_reg;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_HIT_RD;
                    end
                    else
                    begin
                        if (!used_reg[cmp_idx_reg] && !free_vld_reg)
                        begin
                            free_vld_next = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == EW'(TABLE_ENTRIES - 1))
                        begin
                            state_next = ST_ALLOC;
                        end
                    end
                end
            end
            ST_HIT_RD:
            begin
                wait_raddr = hit_idx_reg;
                state_next = ST_HIT_WR;
            end
            ST_HIT_WR:
            begin
                wait_we    = 1'b1;
                wait_waddr = hit_idx_reg;
                wait_wdata = (wait_rd_reg == WAIT_MAX) ? WAIT_MAX : wait_rd_reg + 8'd1;
                state_next = ST_ISSUE;
            end
            ST_ALLOC:
            begin
                if (free_vld_reg)
                begin
                    key_we                  = 1'b1;
                    wait_we                 = 1'b1;
                    pq_we                   = 1'b1;
                    used_next[free_idx_reg] = 1'b1;
                    q_tail_next  = (q_tail_reg == EW'(TABLE_ENTRIES - 1)) ? '0
                                                                         : q_tail_reg + 1'b1;
                    q_count_next = q_count_reg + 1'b1;
                    state_next   = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_REJECT;
                end
            end
            ST_REJECT:
            begin
                if (slot_free)
                begin
                    load             = 1'b1;
                    out_next.kind    = KIND_REJECT;
                    out_next.tag     = (cmd_reg.kind == CMD_DONE) ? cmd_reg.tag : '0;
                    out_next.key     = (cmd_reg.kind == CMD_ADD) ? cmd_reg.key : '0;
                    out_next.waiters = '0;
                    out_next.ok      = 1'b0;
                    out_next.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_DONE_RD:
            begin
                state_next = ST_DONE_ENT;
            end
            ST_DONE_ENT:
            begin
                ent_next   = bm_rd_reg;
                key_raddr  = bm_rd_reg;
                wait_raddr = bm_rd_reg;
                state_next = ST_DONE_EMIT;
            end
            ST_DONE_EMIT:
            begin
                if (slot_free)
                begin
                    load              = 1'b1;
                    out_next.kind     = KIND_DONE;
                    out_next.tag      = TAG_W'(cur_tag_reg);
                    out_next.key      = key_rd_reg;
                    out_next.waiters  = wait_rd_reg;
                    out_next.ok       = cmd_reg.ok;
                    out_next.last     = elem_last;
                    used_next[ent_reg] = 1'b0;
                    if (elem_last)
                    begin
                        tag_busy_next[cur_tag_reg] = 1'b0;
                        blen_next[cur_tag_reg]     = '0;
                        if (inflight_reg != '0)
                        begin
                            inflight_next = inflight_reg - 1'b1;
                        end
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        elem_next  = elem_reg + 1'b1;
                        state_next = ST_DONE_RD;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (32'(inflight_reg) >= 32'(inflight_limit) || q_count_reg == '0 || !ftag_vld)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    tag_busy_next[ftag] = 1'b1;
                    blen_next[ftag]     = LW'(len32);
                    inflight_next       = inflight_reg + 1'b1;
                    cur_tag_next        = ftag;
                    cur_len_next        = LW'(len32);
                    elem_next           = '0;
                    state_next          = ST_ISS_RD;
                end
            end
            ST_ISS_RD:
            begin
                state_next = ST_ISS_ENT;
            end
            ST_ISS_ENT:
            begin
                ent_next     = pq_rd_reg;
                key_raddr    = pq_rd_reg;
                bm_we        = 1'b1;
                q_head_next  = (q_head_reg == EW'(TABLE_ENTRIES - 1)) ? '0 : q_head_reg + 1'b1;
                q_count_next = q_count_reg - 1'b1;
                state_next   = ST_ISS_EMIT;
            end
            ST_ISS_EMIT:
            begin
                if (slot_free)
                begin
                    load             = 1'b1;
                    out_next.kind    = KIND_ISSUE;
                    out_next.tag     = TAG_W'(cur_tag_reg);
                    out_next.key     = key_rd_reg;
                    out_next.waiters = '0;
                    out_next.ok      = 1'b0;
                    out_next.last    = elem_last;
                    if (elem_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        elem_next  = elem_reg + 1'b1;
                        state_next = ST_ISS_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_vld_next = load ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmp_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            used_reg     <= '0;
            tag_busy_reg <= '0;
            for (int k = 0; k < MAX_TAGS; k++)
            begin
                blen_reg[k] <= '0;
            end
            inflight_reg <= '0;
            q_head_reg   <= '0;
            q_tail_reg   <= '0;
            q_count_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmp_vld_reg  <= cmp_vld_next;
            free_vld_reg <= free_vld_next;
            used_reg     <= used_next;
            tag_busy_reg <= tag_busy_next;
            blen_reg     <= blen_next;
            inflight_reg <= inflight_next;
            q_head_reg   <= q_head_next;
            q_tail_reg   <= q_tail_next;
            q_count_reg  <= q_count_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        scan_ptr_reg <= scan_ptr_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        hit_idx_reg  <= hit_idx_next;
        ent_reg      <= ent_next;
        cur_tag_reg  <= cur_tag_next;
        cur_len_reg  <= cur_len_next;
        elem_reg     <= elem_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= cmd_reg.key;
        end
        key_rd_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wait_we)
        begin
            wait_mem[wait_waddr] <= wait_wdata;
        end
        wait_rd_reg <= wait_mem[wait_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pq_we)
        begin
            pq_mem[q_tail_reg] <= free_idx_reg;
        end
        pq_rd_reg <= pq_mem[q_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_addr] <= pq_rd_reg;
        end
        bm_rd_reg <= bm_mem[bm_addr];
    end

    `RCB_ASSERT(a_queue_bound, q_count_reg <= CW'($countones(used_reg)), "queue exceeds used entries")
    `RCB_ASSERT(a_inflight_busy, $countones(tag_busy_reg) == 32'(inflight_reg), "inflight count off")
    `RCB_ASSERT_NEXT(a_alloc_used, state_reg == ST_ALLOC && free_vld_reg, used_reg[free_idx_reg], "entry not marked used")

endmodule
`default_nettype wire

// ----- src/request_coalescing_batcher.sv -----
// request coalescing batcher, top level: channels, registers, front and engine
// depends on rcb_pkg, rcb_front and rcb_engine
//
// input stream s_*: s_tuser is the opcode (add or completion), s_tdata carries
// the query key, the completion tag and the ok flag. output stream m_*: one
// transaction per issued batch element, completed query or rejection; m_tuser
// is the kind and m_tlast marks the last element of a batch or completion run.
// cfg_*: register writes, index 0 is the inflight limit, 1 the batch size limit.
// a two-entry command queue sits between input and engine, and a result
// register sits on the output, so input is still accepted while results
// stall, until the queue is full. an add walks the key table one entry a
// cycle. a completion passes each batch member through ST_DONE_RD/ENT/EMIT,
// and each issued element through ST_ISS_RD/ENT/EMIT.
// reset empties the table, the pending queue and all tags; limits go to 1 and 16.
// when m_tready is low the engine holds at its next result and stops.
`default_nettype none
module request_coalescing_batcher
    import rcb_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_TAGS      = MAX_TAGS_DEF,
    parameter int BATCH_MAX     = BATCH_MAX_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // query_key, done_tag, done_ok
    input  wire logic                   s_tuser,   // opcode
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,   // tag_out, key_out, waiter_total, success
    output logic [KIND_W-1:0]           m_tuser,   // kind
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [ILIM_W-1:0] ilim_reg;
    logic [BLIM_W-1:0] blim_reg;
    logic              cmd_valid, cmd_ready;
    cmd_t              cmd;
    out_t              out_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ilim_reg <= ILIM_RESET;
            blim_reg <= BLIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_INFLIGHT)
            begin
                ilim_reg <= cfg_data[ILIM_W-1:0];
            end
            else if (cfg_index == CFG_BATCH)
            begin
                blim_reg <= cfg_data[BLIM_W-1:0];
            end
        end
    end

    rcb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .query_key (s_tdata[63:0]),
        .done_tag  (s_tdata[66:64]),
        .done_ok   (s_tdata[67]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rcb_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_TAGS      (MAX_TAGS),
        .BATCH_MAX     (BATCH_MAX)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .inflight_limit   (ilim_reg),
        .batch_size_limit (blim_reg),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_item         (out_item)
    );

    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;
    assign m_tdata = {4'd0, out_item.ok, out_item.waiters, out_item.key, out_item.tag};

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for request_coalescing_batcher: directed table, then phased random traffic
// a coalescing/batching predictor in the bench builds the expected result stream
// depends on rcb_pkg and the request_coalescing_batcher rtl
`timescale 1ns / 1ps
module tb_top;
    import rcb_pkg::*;

    localparam int N_ENTRIES = 64;
    localparam int N_TAGS    = 8;
    localparam int B_MAX     = 16;
    localparam int STALL_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = OP_ADD;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    request_coalescing_batcher dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // predictor state
    logic [ILIM_W-1:0] lim_inflight;
    logic [BLIM_W-1:0] lim_batch;
    logic [KEY_W-1:0]  tbl_key [N_ENTRIES];
    logic [WAIT_W-1:0] tbl_waiters [N_ENTRIES];
    bit                tbl_used [N_ENTRIES];
    int                pend_fifo [N_ENTRIES];
    int                pend_head, pend_tail, pend_count;
    int                tag_members [N_TAGS][B_MAX];
    int                tag_len [N_TAGS];
    bit                tag_busy [N_TAGS];
    int                batches_out;

    out_t expected_results [$];
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   rx_gap = 0;
    bit   rx_calm = 1'b0;
    logic [KEY_W-1:0] key_pool [12];

    function automatic void predictor_reset();
        lim_inflight = ILIM_RESET;
        lim_batch = BLIM_RESET;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_waiters[i] = '0;
        end
        for (int t = 0; t < N_TAGS; t++)
        begin
            tag_busy[t] = 1'b0;
            tag_len[t] = 0;
        end
        pend_head = 0;
        pend_tail = 0;
        pend_count = 0;
        batches_out = 0;
    endfunction

    function automatic void expect_result(logic [KIND_W-1:0] kind, int tag, logic [KEY_W-1:0] key,
                                          logic [WAIT_W-1:0] w, logic ok, logic last);
        out_t r;
        r.kind = kind;
        r.tag = tag[TAG_W-1:0];
        r.key = key;
        r.waiters = w;
        r.ok = ok;
        r.last = last;
        expected_results = {expected_results, r};
    endfunction

    function automatic void predict_batch_issue();
        int t, len, bs, e;
        if (batches_out >= lim_inflight || pend_count == 0)
            return;
        for (t = 0; t < N_TAGS; t++)
            if (!tag_busy[t])
                break;
        if (t >= N_TAGS)
            return;
        bs = (lim_batch == 0) ? 1 : (lim_batch > B_MAX ? B_MAX : lim_batch);
        len = (pend_count < bs) ? pend_count : bs;
        tag_busy[t] = 1'b1;
        tag_len[t] = len;
        batches_out++;
        for (int i = 0; i < len; i++)
        begin
            e = pend_fifo[pend_head];
            pend_head = (pend_head + 1) % N_ENTRIES;
            pend_count--;
            tag_members[t][i] = e;
            expect_result(KIND_ISSUE, t, tbl_key[e], '0, 1'b0, i + 1 == len);
        end
    endfunction

    function automatic void predict_request(logic op, logic [KEY_W-1:0] key, int tag, logic ok);
        int free_e, e;
        if (op == OP_ADD)
        begin
            free_e = N_ENTRIES;
            if (key == '0)
            begin
                expect_result(KIND_REJECT, 0, '0, '0, 1'b0, 1'b1);
                return;
            end
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                if (tbl_used[i])
                begin
                    if (tbl_key[i] == key)
                    begin
                        if (tbl_waiters[i] != WAIT_MAX)
                            tbl_waiters[i]++;
                        predict_batch_issue();
                        return;
                    end
                end
                else if (free_e == N_ENTRIES)
                    free_e = i;
            end
            if (free_e == N_ENTRIES)
            begin
                expect_result(KIND_REJECT, 0, key, '0, 1'b0, 1'b1);
                return;
            end
            tbl_used[free_e] = 1'b1;
            tbl_key[free_e] = key;
            tbl_waiters[free_e] = 8'd1;
            pend_fifo[pend_tail] = free_e;
            pend_tail = (pend_tail + 1) % N_ENTRIES;
            pend_count++;
            predict_batch_issue();
        end
        else
        begin
            if (!tag_busy[tag])
            begin
                expect_result(KIND_REJECT, tag, '0, '0, 1'b0, 1'b1);
                return;
            end
            for (int i = 0; i < tag_len[tag]; i++)
            begin
                e = tag_members[tag][i];
                expect_result(KIND_DONE, tag, tbl_key[e], tbl_waiters[e], ok, i + 1 == tag_len[tag]);
                tbl_used[e] = 1'b0;
                tbl_waiters[e] = '0;
            end
            tag_busy[tag] = 1'b0;
            tag_len[tag] = 0;
            if (batches_out > 0)
                batches_out--;
            predict_batch_issue();
        end
    endfunction

    task automatic sender_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // typed: the row carries its own expected result instead of the predictor's
    task automatic send_request(logic op, logic [KEY_W-1:0] key, int tag, logic ok,
                                bit typed = 1'b0, out_t typed_res = '0);
        int prior_count;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, ok, tag[TAG_W-1:0], key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        prior_count = expected_results.size();
        predict_request(op, key, tag, ok);
        if (typed)
        begin
            while (expected_results.size() > prior_count)
                void'(expected_results.pop_back());
            expected_results = {expected_results, typed_res};
        end
        sender_gap();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (N_ENTRIES + 40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_INFLIGHT)
            lim_inflight = val[ILIM_W-1:0];
        else if (idx == CFG_BATCH)
            lim_batch = val[BLIM_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0)
            k = 64'd1;
        return k;
    endfunction

    function automatic int pick_busy_tag();
        int start;
        start = $urandom_range(0, N_TAGS - 1);
        for (int i = 0; i < N_TAGS; i++)
            if (tag_busy[(start + i) % N_TAGS])
                return (start + i) % N_TAGS;
        return -1;
    endfunction

    task automatic random_item();
        int r, t;
        r = $urandom_range(0, 99);
        if (r < 3)
            key_pool[$urandom_range(0, 11)] = rand_key();
        if (r < 42)
            send_request(OP_ADD, key_pool[$urandom_range(0, 11)], 0, $urandom_range(0, 1));
        else if (r < 55)
            send_request(OP_ADD, rand_key(), $urandom_range(0, 7), $urandom_range(0, 1));
        else if (r < 58)
            send_request(OP_ADD, '0, $urandom_range(0, 7), $urandom_range(0, 1));
        else if (r < 62)
            send_request(OP_DONE, rand_key(), $urandom_range(0, 7), $urandom_range(0, 1));
        else
        begin
            t = pick_busy_tag();
            if (t < 0)
                send_request(OP_ADD, key_pool[$urandom_range(0, 11)], 0, 1'b0);
            else
                send_request(OP_DONE, rand_key(), t, $urandom_range(0, 1));
        end
    endtask

    // monitor and watchdog
    always @(posedge clk)
    begin
        out_t got, want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.tag = m_tdata[2:0];
                got.key = m_tdata[66:3];
                got.waiters = m_tdata[74:67];
                got.ok = m_tdata[75];
                got.last = m_tlast;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    // receiver backpressure
    initial begin
        forever
        begin
            @(posedge clk);
            if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm)
                begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        rx_gap = $urandom_range(1, 3);
                    else if (r < 17)
                        rx_gap = $urandom_range(8, 40);
                end
            end
        end
    end

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        int               tag;
        logic             ok;
        bit               typed;
        out_t             res;
    } stim_row_t;

    localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;

    stim_row_t directed [15] = '{
        '{OP_ADD,  64'd0,    5, 1'b1, 1'b1, '{KIND_REJECT, 3'd0, 64'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_DONE, 64'd0,    7, 1'b1, 1'b1, '{KIND_REJECT, 3'd7, 64'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_DONE, KEY_NEG1, 0, 1'b0, 1'b1, '{KIND_REJECT, 3'd0, 64'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADD,  KEY_MIN,  0, 1'b0, 1'b1, '{KIND_ISSUE, 3'd0, KEY_MIN, 8'd0, 1'b0, 1'b1}},
        '{OP_ADD,  KEY_MAX,  0, 1'b0, 1'b0, '0},
        '{OP_ADD,  KEY_NEG1, 7, 1'b1, 1'b0, '0},
        '{OP_ADD,  KEY_MIN,  0, 1'b0, 1'b0, '0},
        '{OP_ADD,  KEY_MAX,  0, 1'b0, 1'b0, '0},
        '{OP_DONE, 64'd0,    0, 1'b1, 1'b0, '0},
        '{OP_DONE, 64'd0,    1, 1'b1, 1'b1, '{KIND_REJECT, 3'd1, 64'd0, 8'd0, 1'b0, 1'b1}},
        '{OP_ADD,  64'd1,    0, 1'b0, 1'b0, '0},
        '{OP_ADD,  KEY_NEG1, 0, 1'b0, 1'b0, '0},
        '{OP_DONE, 64'd0,    0, 1'b0, 1'b0, '0},
        '{OP_DONE, 64'd0,    0, 1'b1, 1'b0, '0},
        '{OP_DONE, 64'd0,    0, 1'b1, 1'b1, '{KIND_REJECT, 3'd0, 64'd0, 8'd0, 1'b0, 1'b1}}
    };

    initial begin
        logic [KEY_W-1:0] sat_key;
        predictor_reset();
        for (int i = 0; i < 12; i++)
            key_pool[i] = rand_key();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
            send_request(directed[i].op, directed[i].key, directed[i].tag, directed[i].ok,
                         directed[i].typed, directed[i].res);
        wait_drained();

        // waiter count saturation on an empty table
        sat_key = rand_key();
        repeat (256) send_request(OP_ADD, sat_key, 0, 1'b0);
        send_request(OP_DONE, '0, pick_busy_tag(), 1'b1);
        wait_drained();

        // many tags, single-key batches (size 0 behaves as 1)
        write_reg(CFG_INFLIGHT, 8'd15);
        write_reg(CFG_BATCH, 8'd0);
        repeat (10) random_item();
        wait_drained();

        // widest settings, data bits above the register width are dropped
        write_reg(CFG_INFLIGHT, 8'hF8);
        write_reg(CFG_BATCH, 8'hFF);
        repeat (10) random_item();
        wait_drained();

        // issue disabled: fill the table until new keys are turned away
        write_reg(4'd9, 8'hAA);
        write_reg(CFG_INFLIGHT, 8'd0);
        write_reg(CFG_BATCH, 8'd16);
        rx_calm = 1'b1;
        repeat (67) send_request(OP_ADD, rand_key(), 0, 1'b0);
        send_request(OP_DONE, '0, $urandom_range(0, 7), 1'b1);
        wait_drained();
        rx_calm = 1'b0;

        write_reg(CFG_INFLIGHT, 8'd3);
        write_reg(CFG_BATCH, 8'd4);
        // receiver stalls for a long stretch while requests keep coming
        rx_gap = 600;
        repeat (12)
        begin
            int slot;
            slot = $urandom_range(0, 11);
            send_request(OP_ADD, key_pool[slot], 0, 1'b0);
        end
        wait_drained();
        rx_calm = 1'b1;
        repeat (10) random_item();
        rx_calm = 1'b0;

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
